>>> src/crsf_pkg.sv
// shared types, register codes and reset defaults for the crsf frame parser
package crsf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 8;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SYNC_ADDR = 8'd0,
    REG_TX_ADDR   = 8'd1,
    REG_RX_ADDR   = 8'd2,
    REG_LEN_LIMIT = 8'd3,
    REG_CRC_POLY  = 8'd4
  } crsf_reg_t;

  // parser phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_LENGTH = 3'b010,
    PH_BODY   = 3'b100
  } crsf_phase_t;

  typedef struct packed {
    logic [ByteW-1:0] sync_address;
    logic [ByteW-1:0] transmitter_address;
    logic [ByteW-1:0] receiver_address;
    logic [ByteW-1:0] length_limit;
    logic [ByteW-1:0] crc_polynomial;
  } crsf_cfg_t;

  typedef struct packed {
    logic             accepted;
    logic [ByteW-1:0] byte_out;
    logic [ByteW-1:0] byte_position;
    logic             in_frame;
    logic             frame_end;
    logic             frame_good;
  } crsf_result_t;

  localparam logic [ByteW-1:0] RstSyncAddr = 8'd200;
  localparam logic [ByteW-1:0] RstTxAddr   = 8'd234;
  localparam logic [ByteW-1:0] RstRxAddr   = 8'd236;
  localparam logic [ByteW-1:0] RstLenLimit = 8'd64;
  localparam logic [ByteW-1:0] RstCrcPoly  = 8'd213;

endpackage

>>> src/crsf_if.sv
// valid/ready channel interfaces for input words, result words and config writes
interface crsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface crsf_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [7:0] byte_out;
  logic [7:0] byte_position;
  logic       in_frame;
  logic       frame_end;
  logic       frame_good;
  modport source (output valid, output accepted, output byte_out, output byte_position,
                  output in_frame, output frame_end, output frame_good, input ready);
  modport sink   (input valid, input accepted, input byte_out, input byte_position,
                  input in_frame, input frame_end, input frame_good, output ready);
endinterface

interface crsf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/crsf_frame_parser_core.sv
// top level of the crsf frame parser: config registers, parser and result buffer
// the result word of an accepted input word is registered before it appears on out_ch
// throughput: one word per cycle while the skid is free; the crc-8 update is xor logic
// the result register plus one skid entry keep input open while a result waits
// reset (rst_n low, synchronous): parser idle, counters and crc zero,
// config registers back to their defaults (addresses 200/234/236, limit 64, poly 0xd5)
module crsf_frame_parser_core (
  input  logic  clk,
  input  logic  rst_n,
  crsf_in_if.sink    in_ch,
  crsf_out_if.source out_ch,
  crsf_cfg_if.sink   cfg_ch
);

  crsf_pkg::crsf_cfg_t    cfg_r;
  crsf_pkg::crsf_result_t result;
  crsf_pkg::crsf_result_t out_data;
  logic                   can_push;
  logic                   in_take;
  logic                   cfg_take;

  // config writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign cfg_take     = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_address        <= crsf_pkg::RstSyncAddr;
      cfg_r.transmitter_address <= crsf_pkg::RstTxAddr;
      cfg_r.receiver_address    <= crsf_pkg::RstRxAddr;
      cfg_r.length_limit        <= crsf_pkg::RstLenLimit;
      cfg_r.crc_polynomial      <= crsf_pkg::RstCrcPoly;
    end else if (cfg_take) begin
      case (cfg_ch.index)
        crsf_pkg::REG_SYNC_ADDR: cfg_r.sync_address        <= cfg_ch.data;
        crsf_pkg::REG_TX_ADDR:   cfg_r.transmitter_address <= cfg_ch.data;
        crsf_pkg::REG_RX_ADDR:   cfg_r.receiver_address    <= cfg_ch.data;
        crsf_pkg::REG_LEN_LIMIT: cfg_r.length_limit        <= cfg_ch.data;
        crsf_pkg::REG_CRC_POLY:  cfg_r.crc_polynomial      <= cfg_ch.data;
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // input is open whenever the skid entry is free
  assign in_ch.ready = can_push;
  assign in_take     = in_ch.valid & can_push;

  // state update and result decode on the accepted word
  crsf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .data_byte (in_ch.data_byte),
    .cfg       (cfg_r),
    .result    (result)
  );

  // result register and skid entry between the two sides
  crsf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_data (result),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.accepted      = out_data.accepted;
  assign out_ch.byte_out      = out_data.byte_out;
  assign out_ch.byte_position = out_data.byte_position;
  assign out_ch.in_frame      = out_data.in_frame;
  assign out_ch.frame_end     = out_data.frame_end;
  assign out_ch.frame_good    = out_data.frame_good;

endmodule

>>> src/crsf_crc8.sv
// byte-wide crc-8 update, msb first, programmable polynomial
module crsf_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  input  logic [7:0] poly,
  output logic [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data_in;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

>>> src/crsf_parser.sv
// frame recognizer: phase, body counter, length and running crc with result logic
module crsf_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  input  crsf_pkg::crsf_cfg_t   cfg,
  output crsf_pkg::crsf_result_t result
);

  crsf_pkg::crsf_phase_t phase_r, phase_nxt;
  logic [7:0] body_count_r, body_count_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] crc_upd;
  logic [7:0] count_inc;

  crsf_crc8 u_crc (
    .crc_in  (crc_r),
    .data_in (data_byte),
    .poly    (cfg.crc_polynomial),
    .crc_out (crc_upd)
  );

  assign count_inc = body_count_r + 8'd1;

  always_comb begin
    phase_nxt        = crsf_pkg::PH_IDLE;
    body_count_nxt   = body_count_r;
    frame_length_nxt = frame_length_r;
    crc_nxt          = crc_r;
    result           = '0;
    result.byte_out  = data_byte;
    case (phase_r)
      crsf_pkg::PH_LENGTH: begin
        result.byte_position = 8'd1;
        // zero length or a length at or above the limit drops back to idle
        if (data_byte != 8'd0 && data_byte < cfg.length_limit) begin
          frame_length_nxt = data_byte;
          body_count_nxt   = 8'd0;
          crc_nxt          = 8'd0;
          phase_nxt        = crsf_pkg::PH_BODY;
          result.accepted  = 1'b1;
          result.in_frame  = 1'b1;
        end
      end
      crsf_pkg::PH_BODY: begin
        result.byte_position = body_count_r + 8'd2;
        result.in_frame      = 1'b1;
        body_count_nxt       = count_inc;
        if (count_inc == frame_length_r) begin
          // last body word is the received crc
          result.frame_end  = 1'b1;
          result.frame_good = (data_byte == crc_r);
          result.accepted   = (data_byte == crc_r);
        end else begin
          crc_nxt         = crc_upd;
          phase_nxt       = crsf_pkg::PH_BODY;
          result.accepted = 1'b1;
        end
      end
      default: begin
        if (data_byte == cfg.sync_address || data_byte == cfg.transmitter_address ||
            data_byte == cfg.receiver_address) begin
          body_count_nxt  = 8'd0;
          phase_nxt       = crsf_pkg::PH_LENGTH;
          result.accepted = 1'b1;
          result.in_frame = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= crsf_pkg::PH_IDLE;
      body_count_r   <= 8'd0;
      frame_length_r <= 8'd0;
      crc_r          <= 8'd0;
    end else if (take) begin
      phase_r        <= phase_nxt;
      body_count_r   <= body_count_nxt;
      frame_length_r <= frame_length_nxt;
      crc_r          <= crc_nxt;
    end
  end

endmodule

>>> src/crsf_out_buf.sv
// result register with one skid entry
module crsf_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  crsf_pkg::crsf_result_t push_data,
  output logic                   can_push,
  output logic                   out_valid,
  input  logic                   out_ready,
  output crsf_pkg::crsf_result_t out_data
);

  logic                   out_valid_r;
  logic                   skid_valid_r;
  crsf_pkg::crsf_result_t out_data_r;
  crsf_pkg::crsf_result_t skid_data_r;
  logic                   pop;

  assign pop       = out_valid_r & out_ready;
  assign can_push  = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end
  end

endmodule

>>> src/crsf_frame_parser_chk.sv
// port-level checker for the crsf frame parser, bound to the top level
module crsf_frame_parser_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       accepted,
  input logic [7:0] byte_position,
  input logic       in_frame,
  input logic       frame_end,
  input logic       frame_good
);

  // a good frame flag only comes with a frame end
  a_good_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_good |-> frame_end)
    else $error("frame_good without frame_end");

  // frame end verdict: accepted follows the crc check, word belongs to the frame
  a_end_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_end |-> in_frame && (accepted == frame_good))
    else $error("frame end verdict inconsistent");

  // accepted words are always frame words
  a_accept_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && accepted |-> in_frame)
    else $error("accepted word outside a frame");

  // a stalled result stays valid
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // frame end is never on address or length position
  a_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_end |-> byte_position != 8'd0 && byte_position != 8'd1)
    else $error("frame end at header position");

endmodule

bind crsf_frame_parser_core crsf_frame_parser_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .accepted      (out_ch.accepted),
  .byte_position (out_ch.byte_position),
  .in_frame      (out_ch.in_frame),
  .frame_end     (out_ch.frame_end),
  .frame_good    (out_ch.frame_good)
);

>>> tb/tb_top.sv
// self-checking testbench for crsf_frame_parser_core: frame tracker, drivers, phases
module tb_top;

  // tracks the parser state from the accepted input words and holds the
  // result words that are still due on the output channel
  class crsf_frame_tracker;
    crsf_pkg::crsf_cfg_t    settings;
    crsf_pkg::crsf_phase_t  ph;
    logic [7:0]             body_cnt;
    logic [7:0]             flen;
    logic [7:0]             crc_acc;
    crsf_pkg::crsf_result_t due[$];
    int                     errors;
    int                     good_frames;
    int                     bad_frames;
    int                     rejects;

    function new();
      settings.sync_address        = crsf_pkg::RstSyncAddr;
      settings.transmitter_address = crsf_pkg::RstTxAddr;
      settings.receiver_address    = crsf_pkg::RstRxAddr;
      settings.length_limit        = crsf_pkg::RstLenLimit;
      settings.crc_polynomial      = crsf_pkg::RstCrcPoly;
      ph       = crsf_pkg::PH_IDLE;
      body_cnt = '0;
      flen     = '0;
      crc_acc  = '0;
      errors   = 0;
      good_frames = 0;
      bad_frames  = 0;
      rejects     = 0;
    endfunction

    function void write_reg(crsf_pkg::crsf_reg_t r, logic [7:0] v);
      case (r)
        crsf_pkg::REG_SYNC_ADDR: settings.sync_address        = v;
        crsf_pkg::REG_TX_ADDR:   settings.transmitter_address = v;
        crsf_pkg::REG_RX_ADDR:   settings.receiver_address    = v;
        crsf_pkg::REG_LEN_LIMIT: settings.length_limit        = v;
        crsf_pkg::REG_CRC_POLY:  settings.crc_polynomial      = v;
        default: ;
      endcase
    endfunction

    // msb-first crc-8 over one byte with the current polynomial
    function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
      logic [7:0] r;
      r = c ^ b;
      for (int i = 0; i < 8; i++) begin
        if (r[7]) begin
          r = (r << 1) ^ settings.crc_polynomial;
        end else begin
          r = r << 1;
        end
      end
      return r;
    endfunction

    function logic [7:0] crc_of(logic [7:0] q[$]);
      logic [7:0] c;
      c = '0;
      foreach (q[i]) c = crc_step(c, q[i]);
      return c;
    endfunction

    function bit is_address(logic [7:0] b);
      return b == settings.sync_address || b == settings.transmitter_address ||
             b == settings.receiver_address;
    endfunction

    function void note_byte(logic [7:0] b);
      crsf_pkg::crsf_result_t r;
      r = '0;
      r.byte_out = b;
      case (ph)
        crsf_pkg::PH_LENGTH: begin
          r.byte_position = 8'd1;
          if (b == 8'd0 || b >= settings.length_limit) begin
            ph = crsf_pkg::PH_IDLE;
            rejects++;
          end else begin
            flen     = b;
            body_cnt = '0;
            crc_acc  = '0;
            ph       = crsf_pkg::PH_BODY;
            r.accepted = 1'b1;
            r.in_frame = 1'b1;
          end
        end
        crsf_pkg::PH_BODY: begin
          r.byte_position = body_cnt + 8'd2;
          r.in_frame = 1'b1;
          body_cnt = body_cnt + 8'd1;
          if (body_cnt == flen) begin
            r.frame_end  = 1'b1;
            r.frame_good = (b == crc_acc);
            r.accepted   = r.frame_good;
            ph = crsf_pkg::PH_IDLE;
            if (r.frame_good) good_frames++;
            else bad_frames++;
          end else begin
            crc_acc = crc_step(crc_acc, b);
            r.accepted = 1'b1;
          end
        end
        default: begin
          ph = crsf_pkg::PH_IDLE;
          if (is_address(b)) begin
            body_cnt   = '0;
            ph         = crsf_pkg::PH_LENGTH;
            r.accepted = 1'b1;
            r.in_frame = 1'b1;
          end
        end
      endcase
      due.push_back(r);
    endfunction

    function void cmp_field(string name, logic [7:0] e, logic [7:0] g);
      if (e !== g) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, g);
      end
    endfunction

    function void check_word(crsf_pkg::crsf_result_t got);
      crsf_pkg::crsf_result_t e;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing due, expected none, got byte %h",
                 $time, got.byte_out);
      end else begin
        e = due.pop_front();
        cmp_field("accepted",      8'(e.accepted),   8'(got.accepted));
        cmp_field("byte_out",      e.byte_out,       got.byte_out);
        cmp_field("byte_position", e.byte_position,  got.byte_position);
        cmp_field("in_frame",      8'(e.in_frame),   8'(got.in_frame));
        cmp_field("frame_end",     8'(e.frame_end),  8'(got.frame_end));
        cmp_field("frame_good",    8'(e.frame_good), 8'(got.frame_good));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  crsf_in_if  in_w ();
  crsf_out_if out_w ();
  crsf_cfg_if cfg_w ();

  crsf_frame_parser_core i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_w),
    .out_ch(out_w),
    .cfg_ch(cfg_w)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  crsf_frame_tracker tracker = new();

  int words_sent = 0;
  int settings_used = 1;
  bit src_calm = 1'b0;   // source runs without gaps while set
  bit snk_calm = 1'b0;   // sink takes every word while set

  // present one input word, after a random gap, and hold it until taken;
  // called right after a rising edge
  task automatic push_byte(logic [7:0] b);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_w.valid     <= 1'b1;
    in_w.data_byte <= b;
    do @(posedge clk); while (!(in_w.valid && in_w.ready));
    tracker.note_byte(b);
    words_sent++;
  endtask

  // one register write; valid stays up so writes can run back to back
  task automatic cfg_put(crsf_pkg::crsf_reg_t r, logic [7:0] v);
    cfg_w.valid <= 1'b1;
    cfg_w.index <= r;
    cfg_w.data  <= v;
    do @(posedge clk); while (!(cfg_w.valid && cfg_w.ready));
    tracker.write_reg(r, v);
  endtask

  task automatic load_settings(crsf_pkg::crsf_cfg_t s);
    cfg_put(crsf_pkg::REG_SYNC_ADDR, s.sync_address);
    cfg_put(crsf_pkg::REG_TX_ADDR,   s.transmitter_address);
    cfg_put(crsf_pkg::REG_RX_ADDR,   s.receiver_address);
    cfg_put(crsf_pkg::REG_LEN_LIMIT, s.length_limit);
    cfg_put(crsf_pkg::REG_CRC_POLY,  s.crc_polynomial);
    cfg_w.valid <= 1'b0;
    settings_used++;
  endtask

  // stop the input side and wait until every due result word has come back,
  // then let the result register and skid entry settle
  task automatic drain_out();
    in_w.valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_address();
    case ($urandom_range(0, 2))
      0: return tracker.settings.sync_address;
      1: return tracker.settings.transmitter_address;
      default: return tracker.settings.receiver_address;
    endcase
  endfunction

  // address, length, len-1 random body words and a crc word, good or corrupted
  task automatic send_frame(logic [7:0] addr, logic [7:0] len, bit corrupt);
    logic [7:0] body[$];
    logic [7:0] c;
    for (int i = 1; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
    c = tracker.crc_of(body);
    if (corrupt) c = c ^ 8'($urandom_range(1, 255));
    push_byte(addr);
    push_byte(len);
    foreach (body[i]) push_byte(body[i]);
    push_byte(c);
  endtask

  // mostly well-formed frames, some bad lengths and some loose noise words
  task automatic run_random(int count);
    int start;
    int sel;
    int lim;
    int len;
    start = words_sent;
    while (words_sent - start < count) begin
      if ($urandom_range(0, 4) == 0) src_calm = !src_calm;
      lim = int'(tracker.settings.length_limit);
      sel = $urandom_range(0, 9);
      if (sel <= 6) begin
        // keep frames short as a rule, now and then up to one below the limit
        if ($urandom_range(0, 9) == 0 || lim - 1 < 12) len = $urandom_range(1, lim - 1);
        else len = $urandom_range(1, 12);
        send_frame(pick_address(), 8'(len), $urandom_range(0, 5) == 0);
      end else if (sel == 7) begin
        push_byte(pick_address());
        if ($urandom_range(0, 1) == 0) push_byte(8'd0);
        else push_byte(8'($urandom_range(lim, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) push_byte(pick_address());
          else push_byte(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // result side: random stalls, with stretches of none
  initial begin
    int stall;
    out_w.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) snk_calm = !snk_calm;
      stall = snk_calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_w.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_w.ready <= 1'b1;
      do @(posedge clk); while (!(out_w.valid && out_w.ready));
      tracker.check_word('{accepted:      out_w.accepted,
                           byte_out:      out_w.byte_out,
                           byte_position: out_w.byte_position,
                           in_frame:      out_w.in_frame,
                           frame_end:     out_w.frame_end,
                           frame_good:    out_w.frame_good});
    end
  end

  initial begin
    crsf_pkg::crsf_cfg_t s;
    rst_n          <= 1'b0;
    in_w.valid     <= 1'b0;
    in_w.data_byte <= '0;
    cfg_w.valid    <= 1'b0;
    cfg_w.index    <= '0;
    cfg_w.data     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under the reset defaults
    send_frame(crsf_pkg::RstSyncAddr, 8'd1, 1'b0);   // length one, crc compared with zero
    push_byte(8'h00);                                // non-address words in idle
    push_byte(8'hff);
    push_byte(crsf_pkg::RstTxAddr);                  // zero length is rejected
    push_byte(8'd0);
    push_byte(crsf_pkg::RstRxAddr);                  // length at the limit is rejected
    push_byte(crsf_pkg::RstLenLimit);
    push_byte(crsf_pkg::RstRxAddr);                  // the bad length word is not an address
    push_byte(crsf_pkg::RstLenLimit - 8'd1);
    drain_out();
    send_frame(crsf_pkg::RstRxAddr, 8'd3, 1'b0);     // good crc, inside the open frame's body
    send_frame(crsf_pkg::RstSyncAddr, 8'd2, 1'b1);   // crc mismatch, also inside that body
    send_frame(crsf_pkg::RstTxAddr, 8'd4, 1'b0);
    drain_out();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: s = '{sync_address: 8'd0, transmitter_address: 8'd255, receiver_address: 8'h80,
                 length_limit: 8'd2, crc_polynomial: 8'd0};
        1: s = '{sync_address: 8'd255, transmitter_address: 8'd0, receiver_address: 8'd1,
                 length_limit: 8'd255, crc_polynomial: 8'd255};
        2: s = '{sync_address: crsf_pkg::RstSyncAddr,
                 transmitter_address: crsf_pkg::RstTxAddr,
                 receiver_address: crsf_pkg::RstRxAddr,
                 length_limit: crsf_pkg::RstLenLimit,
                 crc_polynomial: crsf_pkg::RstCrcPoly};
        default: s = '{sync_address: 8'($urandom_range(0, 255)),
                       transmitter_address: 8'($urandom_range(0, 255)),
                       receiver_address: 8'($urandom_range(0, 255)),
                       length_limit: 8'($urandom_range(2, 255)),
                       crc_polynomial: 8'($urandom_range(0, 255))};
      endcase
      load_settings(s);
      run_random(235);
      drain_out();
    end

    $display("covered %0d input words over %0d register settings", words_sent, settings_used);
    $display("frames with matching crc %0d, with mismatch %0d, rejected lengths %0d",
             tracker.good_frames, tracker.bad_frames, tracker.rejects);
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #(12 * 600000);
    $display("FAIL");
    $finish;
  end

endmodule
